FILE: sv/scope_allocator_with_sequence_counters_macros.svh
// Assertion macros used by the scope allocator RTL.
`ifndef SCOPE_ALLOCATOR_WITH_SEQUENCE_COUNTERS_MACROS_SVH
`define SCOPE_ALLOCATOR_WITH_SEQUENCE_COUNTERS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sca_pkg.sv
// Types and constants shared by the scope allocator modules.
package sca_pkg;

    localparam int CMD_W       = 2;
    localparam int SCOPE_ID_W  = 5;
    localparam int ID_SLOTS    = 32;
    localparam int SEQ_OUT_W   = 48;
    localparam int FIRST_SEQ_W = 16;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_IDX_W   = 1;
    localparam int STATUS_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC      = 2'd0,
        CMD_DESTROY    = 2'd1,
        CMD_COLL_SEQ   = 2'd2,
        CMD_ROOTED_SEQ = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_LIVE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_SEQ    = 1'b0,
        CFG_ROOTED_START = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [SCOPE_ID_W-1:0] scope_id;
        logic                  is_global;
    } req_t;

    typedef struct packed {
        logic [SCOPE_ID_W-1:0] scope_out;
        status_t               status;
    } map_res_t;

endpackage

FILE: sv/sca_ifs.sv
// Valid/ready channel interfaces for requests and responses.
interface sca_req_if;
    import sca_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic [SCOPE_ID_W-1:0] scope_id;
    logic                  is_global;

    modport source (output valid, cmd, scope_id, is_global, input ready);
    modport sink   (input valid, cmd, scope_id, is_global, output ready);
endinterface

interface sca_rsp_if;
    import sca_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SCOPE_ID_W-1:0] scope_out;
    logic [SEQ_OUT_W-1:0]  sequence_res;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, scope_out, sequence_res, status, input ready);
    modport sink   (input valid, scope_out, sequence_res, status, output ready);
endinterface

FILE: sv/sca_scope_map.sv
// Live-scope bitmap with allocate and destroy logic.
`include "scope_allocator_with_sequence_counters_macros.svh"

module sca_scope_map #(
    parameter int SCOPE_COUNT = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  sca_pkg::req_t     req,
    output sca_pkg::map_res_t res
);
    import sca_pkg::*;

    localparam int IDXW = $clog2(SCOPE_COUNT);

    logic [SCOPE_COUNT-1:0] live_map_reg;
    logic [SCOPE_COUNT-1:0] live_map_next;
    logic [IDXW-1:0]        lo_idx;
    logic [IDXW-1:0]        hi_idx;
    logic [IDXW-1:0]        free_idx;
    logic [IDXW-1:0]        alloc_idx;
    logic [IDXW-1:0]        sid_idx;
    logic                   full;
    logic                   sid_live;

    // Priority encoders over the bitmap: lowest live, highest live, lowest free.
    always_comb
    begin
        lo_idx   = '0;
        hi_idx   = '0;
        free_idx = '0;
        for (int i = SCOPE_COUNT - 1; i >= 0; i--)
        begin
            if (live_map_reg[i])
            begin
                lo_idx = IDXW'(i);
            end
            if (!live_map_reg[i])
            begin
                free_idx = IDXW'(i);
            end
        end
        for (int i = 0; i < SCOPE_COUNT; i++)
        begin
            if (live_map_reg[i])
            begin
                hi_idx = IDXW'(i);
            end
        end
    end

    always_comb
    begin
        full = &live_map_reg;
        if (live_map_reg == '0)
        begin
            alloc_idx = '0;
        end
        else if (hi_idx != IDXW'(SCOPE_COUNT - 1))
        begin
            alloc_idx = hi_idx + IDXW'(1);
        end
        else if (lo_idx != '0)
        begin
            alloc_idx = lo_idx - IDXW'(1);
        end
        else
        begin
            alloc_idx = free_idx;
        end
    end

    // Scope numbers past the pool are never live.
    assign sid_idx  = IDXW'(req.scope_id);
    assign sid_live = (int'(req.scope_id) < SCOPE_COUNT) && live_map_reg[sid_idx];

    always_comb
    begin
        live_map_next = live_map_reg;
        res.scope_out = '0;
        res.status    = ST_OK;
        unique case (req.cmd)
            CMD_ALLOC:
            begin
                if (full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    live_map_next[alloc_idx] = 1'b1;
                    res.scope_out            = SCOPE_ID_W'(alloc_idx);
                end
            end
            CMD_DESTROY:
            begin
                if (sid_live)
                begin
                    live_map_next[sid_idx] = 1'b0;
                end
                else
                begin
                    res.status = ST_NOT_LIVE;
                end
            end
            CMD_COLL_SEQ, CMD_ROOTED_SEQ:
            begin
                live_map_next = live_map_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_map_reg <= '0;
        end
        else if (commit)
        begin
            live_map_reg <= live_map_next;
        end
    end

    `SCA_ASSERT_IMPL(a_full_only_when_all_live, commit && res.status == ST_FULL, &live_map_reg, "full reported while a scope is free")
    `SCA_ASSERT_IMPL(a_grant_was_free, commit && req.cmd == CMD_ALLOC && res.status == ST_OK, !live_map_reg[alloc_idx], "allocate granted a live scope")
    `SCA_ASSERT_NEXT(a_grant_becomes_live, commit && req.cmd == CMD_ALLOC && res.status == ST_OK, live_map_reg[$past(alloc_idx)], "granted scope not marked live")
    `SCA_ASSERT_NEXT(a_destroy_clears, commit && req.cmd == CMD_DESTROY && res.status == ST_OK, !live_map_reg[$past(sid_idx)], "destroyed scope still live")

endmodule

FILE: sv/sca_seq_ctr.sv
// Per-scope, global and rooted sequence counters with the configuration registers.
module sca_seq_ctr #(
    parameter int SCOPE_COUNT = 32,
    parameter int SEQ_BITS    = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             commit,
    input  sca_pkg::req_t                    req,
    input  logic                             cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sca_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic [SEQ_BITS-1:0]              seq
);
    import sca_pkg::*;

    // The scope number replaces a field at the top of the seed.
    localparam int SEED_OFF = (SEQ_BITS > SCOPE_COUNT) ? SEQ_BITS - SCOPE_COUNT : 0;
    localparam int SEED_FW  = (SCOPE_COUNT < SEQ_BITS - SEED_OFF) ?
                              SCOPE_COUNT : SEQ_BITS - SEED_OFF;
    localparam logic [SEQ_BITS-1:0] SEED_MASK =
        ({SEQ_BITS{1'b1}} >> (SEQ_BITS - SEED_FW)) << SEED_OFF;

    logic [FIRST_SEQ_W-1:0] first_seq_reg;
    logic [SEQ_BITS-1:0]    rooted_ctr_reg;
    logic [ID_SLOTS-1:0]    seeded_reg;
    logic                   global_seeded_reg;
    logic [SEQ_BITS-1:0]    global_ctr_reg;
    logic [SEQ_BITS-1:0]    scope_ctr_reg [ID_SLOTS];

    logic [SEQ_BITS-1:0]    seed;
    logic [SEQ_BITS-1:0]    scope_cur;
    logic [SEQ_BITS-1:0]    global_cur;
    logic                   coll_commit;

    always_comb
    begin
        seed = (SEQ_BITS'(first_seq_reg) & ~SEED_MASK) |
               ((SEQ_BITS'(req.scope_id) << SEED_OFF) & SEED_MASK);
        scope_cur  = seeded_reg[req.scope_id] ? scope_ctr_reg[req.scope_id] : seed;
        global_cur = global_seeded_reg ? global_ctr_reg : SEQ_BITS'(first_seq_reg);
        unique case (req.cmd)
            CMD_COLL_SEQ:   seq = req.is_global ? global_cur : scope_cur;
            CMD_ROOTED_SEQ: seq = rooted_ctr_reg;
            CMD_ALLOC, CMD_DESTROY: seq = '0;
        endcase
    end

    assign coll_commit = commit && (req.cmd == CMD_COLL_SEQ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_seq_reg     <= '0;
            rooted_ctr_reg    <= '0;
            seeded_reg        <= '0;
            global_seeded_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_FIRST_SEQ:    first_seq_reg  <= cfg_wdata[FIRST_SEQ_W-1:0];
                    CFG_ROOTED_START: rooted_ctr_reg <= SEQ_BITS'(cfg_wdata);
                endcase
            end
            else if (commit && req.cmd == CMD_ROOTED_SEQ)
            begin
                rooted_ctr_reg <= rooted_ctr_reg + SEQ_BITS'(1);
            end
            if (coll_commit && req.is_global)
            begin
                global_seeded_reg <= 1'b1;
            end
            if (coll_commit && !req.is_global)
            begin
                seeded_reg[req.scope_id] <= 1'b1;
            end
        end
    end

    // Counter storage needs no reset: it is read only after its seeded flag is set.
    always_ff @(posedge clk)
    begin
        if (coll_commit && req.is_global)
        begin
            global_ctr_reg <= global_cur + SEQ_BITS'(1);
        end
        if (coll_commit && !req.is_global)
        begin
            scope_ctr_reg[req.scope_id] <= scope_cur + SEQ_BITS'(1);
        end
    end

endmodule

FILE: sv/scope_allocator_with_sequence_counters.sv
// Scope allocator top level: request register, scope bitmap, counters, response register.
// An accepted request is held in the request register, then in the response register.
// Throughput: one request per cycle unless rsp stalls; the bitmap and counters do
// their read-modify-write between the request register and the response register.
// Reset clears the live bitmap, seeded flags, first_sequence and the rooted counter.
// No clearing pass runs after reset; requests are taken from the first cycle.
module scope_allocator_with_sequence_counters #(
    parameter int SCOPE_COUNT = 32,
    parameter int SEQ_BITS    = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sca_req_if.sink                         req,
    sca_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sca_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import sca_pkg::*;

    logic                  in_valid_reg;
    req_t                  req_reg;
    logic                  out_valid_reg;
    logic [SCOPE_ID_W-1:0] scope_out_reg;
    logic [SEQ_OUT_W-1:0]  seq_out_reg;
    status_t               status_reg;

    logic                  advance;
    map_res_t              map_res;
    logic [SEQ_BITS-1:0]   seq;

    // The held request moves to the response register when that register is free
    // or its transfer completes in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= '{cmd: cmd_t'(req.cmd), scope_id: req.scope_id,
                         is_global: req.is_global};
        end
        if (advance)
        begin
            scope_out_reg <= map_res.scope_out;
            status_reg    <= map_res.status;
            seq_out_reg   <= SEQ_OUT_W'(seq);
        end
    end

    sca_scope_map #(
        .SCOPE_COUNT (SCOPE_COUNT)
    ) u_scope_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .req    (req_reg),
        .res    (map_res)
    );

    sca_seq_ctr #(
        .SCOPE_COUNT (SCOPE_COUNT),
        .SEQ_BITS    (SEQ_BITS)
    ) u_seq_ctr (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (advance),
        .req       (req_reg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .seq       (seq)
    );

    assign rsp.valid        = out_valid_reg;
    assign rsp.scope_out    = scope_out_reg;
    assign rsp.sequence_res = seq_out_reg;
    assign rsp.status       = status_reg;

endmodule
